@@ rtl/core/stop_and_wait_link_client_unit_assert.svh @@
// assertion macros used by the link client back part
`ifndef STOP_AND_WAIT_LINK_CLIENT_UNIT_ASSERT_SVH
`define STOP_AND_WAIT_LINK_CLIENT_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SWLC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("link client check failed");

// antecedent implies consequent in the next cycle
`define SWLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("link client check failed");

`endif

@@ rtl/core/swlc_pkg.sv @@
// shared types, codes and helpers of the stop-and-wait link client
package swlc_pkg;

    // action codes of an input item
    localparam logic [2:0] ACT_OPEN       = 3'd0;
    localparam logic [2:0] ACT_CLOSE      = 3'd1;
    localparam logic [2:0] ACT_COMMAND    = 3'd2;
    localparam logic [2:0] ACT_RX_CONNECT = 3'd3;
    localparam logic [2:0] ACT_RX_STATUS  = 3'd4;
    localparam logic [2:0] ACT_RX_CLOSE   = 3'd5;
    localparam logic [2:0] ACT_TICK       = 3'd6;

    // link states
    localparam logic [1:0] LINK_DISC = 2'd0;
    localparam logic [1:0] LINK_HAND = 2'd1;
    localparam logic [1:0] LINK_CONN = 2'd2;

    // packet types
    localparam logic [1:0] PKT_CONNECT = 2'd0;
    localparam logic [1:0] PKT_ACTION  = 2'd1;
    localparam logic [1:0] PKT_CLOSE   = 2'd2;

    // result kinds
    localparam logic KIND_PACKET  = 1'b0;
    localparam logic KIND_OUTCOME = 1'b1;

    // command outcomes
    localparam logic [1:0] OUT_ACKED  = 2'd0;
    localparam logic [1:0] OUT_NO_ACK = 2'd1;
    localparam logic [1:0] OUT_BEYOND = 2'd2;

    // configuration register indexes and reset values
    localparam logic CFG_ACK_TIMEOUT  = 1'b0;
    localparam logic CFG_MAX_ATTEMPTS = 1'b1;
    localparam logic [15:0] RST_ACK_TIMEOUT  = 16'd5000;
    localparam logic [2:0]  RST_MAX_ATTEMPTS = 3'd5;

    localparam logic [31:0] CHAL_INVERT = 32'hFFFF_FFFF;

    // job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  peer_id;
        logic [7:0]  command_code;
        logic        rx_flag_syn;
        logic        rx_flag_ack;
        logic        rx_flag_nak;
        logic [15:0] rx_seq;
        logic [31:0] rx_challenge;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [1:0]  packet_type;
        logic [7:0]  destination;
        logic        flag_syn;
        logic        flag_ack;
        logic [15:0] packet_seq;
        logic [31:0] packet_word;
        logic [1:0]  outcome;
        logic        last;
    } t_out_item;

    // one queued job: its first result, and whether a no-ack outcome follows
    typedef struct packed {
        logic      two;
        t_out_item first;
    } t_job;

    // push side of the job queue
    typedef struct packed {
        logic valid;
        t_job job;
    } t_job_push;

    function automatic t_out_item mk_packet(logic [1:0] ptype, logic [7:0] dest,
                                            logic syn, logic ack,
                                            logic [15:0] seq, logic [31:0] word);
        t_out_item r;
        r.result_kind = KIND_PACKET;
        r.packet_type = ptype;
        r.destination = dest;
        r.flag_syn    = syn;
        r.flag_ack    = ack;
        r.packet_seq  = seq;
        r.packet_word = word;
        r.outcome     = OUT_ACKED;
        r.last        = 1'b1;
        return r;
    endfunction

    function automatic t_out_item mk_outcome(logic [1:0] oc);
        t_out_item r;
        r             = '0;
        r.result_kind = KIND_OUTCOME;
        r.outcome     = oc;
        r.last        = 1'b1;
        return r;
    endfunction

endpackage

@@ rtl/core/swlc_front.sv @@
// front part: accepts items, keeps link state and queues a job for items with results
module swlc_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  swlc_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    output swlc_pkg::t_job_push  o_push
);
    import swlc_pkg::*;

    logic [15:0] r_timeout,  n_timeout;
    logic [2:0]  r_max_att,  n_max_att;
    logic [1:0]  r_link,     n_link;
    logic [15:0] r_next_seq, n_next_seq;
    logic [7:0]  r_partner,  n_partner;
    logic        r_awaiting, n_awaiting;
    logic [2:0]  r_attempts, n_attempts;
    logic [15:0] r_timer,    n_timer;
    logic [15:0] r_best_ack, n_best_ack;
    logic        r_best_ok,  n_best_ok;
    logic [7:0]  r_held,     n_held;

    logic [15:0] timer_inc;
    logic [2:0]  att_inc;
    logic        do_judge;
    logic [15:0] judge_ack;
    t_job_push   push;

    assign timer_inc = r_timer + 16'd1;
    assign att_inc   = r_attempts + 3'd1;

    // configuration writes
    always_comb begin
        n_timeout = r_timeout;
        n_max_att = r_max_att;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACK_TIMEOUT:  n_timeout = i_cfg_data;
                CFG_MAX_ATTEMPTS: n_max_att = i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // item classification and state update
    always_comb begin
        n_link     = r_link;
        n_next_seq = r_next_seq;
        n_partner  = r_partner;
        n_awaiting = r_awaiting;
        n_attempts = r_attempts;
        n_timer    = r_timer;
        n_best_ack = r_best_ack;
        n_best_ok  = r_best_ok;
        n_held     = r_held;
        push       = '0;
        do_judge   = 1'b0;
        judge_ack  = 16'd0;

        if (i_accept) begin
            case (i_item.action)
                ACT_OPEN: begin
                    if (r_link == LINK_DISC) begin
                        push.valid = 1'b1;
                        push.job.first = mk_packet(PKT_CONNECT, i_item.peer_id, 1'b1,
                                                   1'b0, r_next_seq, 32'd0);
                        n_partner  = i_item.peer_id;
                        n_link     = LINK_HAND;
                        n_next_seq = r_next_seq + 16'd1;
                    end
                end
                ACT_CLOSE: begin
                    push.valid = 1'b1;
                    push.job.first = mk_packet(PKT_CLOSE, r_partner, 1'b0, 1'b1,
                                               r_next_seq, 32'd0);
                    n_link     = LINK_DISC;
                    n_next_seq = 16'd0;
                    n_awaiting = 1'b0;
                end
                ACT_COMMAND: begin
                    if (!r_awaiting) begin
                        n_held     = i_item.command_code;
                        n_awaiting = 1'b1;
                        n_attempts = 3'd0;
                        n_timer    = 16'd0;
                        n_best_ack = 16'd0;
                        n_best_ok  = 1'b0;
                        push.valid = 1'b1;
                        push.job.first = mk_packet(PKT_ACTION, r_partner, 1'b0, 1'b0,
                                                   r_next_seq,
                                                   {24'd0, i_item.command_code});
                    end
                end
                ACT_RX_CONNECT: begin
                    if (r_link == LINK_HAND && i_item.rx_flag_syn && i_item.rx_flag_ack) begin
                        push.valid = 1'b1;
                        push.job.first = mk_packet(PKT_CONNECT, r_partner, 1'b0, 1'b1,
                                                   16'd0, i_item.rx_challenge ^ CHAL_INVERT);
                        n_link = LINK_CONN;
                    end
                end
                ACT_RX_STATUS: begin
                    if (!i_item.rx_flag_nak && r_awaiting) begin
                        if (!r_best_ok || i_item.rx_seq > r_best_ack) begin
                            n_best_ack = i_item.rx_seq;
                        end
                        n_best_ok = 1'b1;
                    end
                end
                ACT_RX_CLOSE: begin
                    n_next_seq = 16'd0;
                    n_link     = LINK_DISC;
                    n_partner  = 8'd0;
                end
                ACT_TICK: begin
                    if (r_awaiting) begin
                        if (r_best_ok) begin
                            do_judge  = 1'b1;
                            judge_ack = r_best_ack;
                        end else begin
                            n_timer = timer_inc;
                            if (timer_inc >= r_timeout) begin
                                do_judge = 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        // judge the collected ack at the end of a wait
        if (do_judge) begin
            n_attempts = att_inc;
            n_timer    = 16'd0;
            n_best_ok  = 1'b0;
            n_best_ack = 16'd0;
            push.valid = 1'b1;
            if (judge_ack > r_next_seq) begin
                n_awaiting = 1'b0;
                push.job.first = mk_outcome(OUT_BEYOND);
            end else if (judge_ack == r_next_seq) begin
                n_awaiting = 1'b0;
                n_next_seq = r_next_seq + 16'd1;
                push.job.first = mk_outcome(OUT_ACKED);
            end else if (att_inc >= r_max_att) begin
                push.job.first = mk_packet(PKT_CLOSE, r_partner, 1'b0, 1'b1,
                                           r_next_seq, 32'd0);
                push.job.first.last = 1'b0;
                push.job.two = 1'b1;
                n_link     = LINK_DISC;
                n_next_seq = 16'd0;
                n_awaiting = 1'b0;
            end else begin
                push.job.first = mk_packet(PKT_ACTION, r_partner, 1'b0, 1'b0,
                                           r_next_seq, {24'd0, r_held});
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout  <= RST_ACK_TIMEOUT;
            r_max_att  <= RST_MAX_ATTEMPTS;
            r_link     <= LINK_DISC;
            r_next_seq <= 16'd0;
            r_partner  <= 8'd0;
            r_awaiting <= 1'b0;
            r_attempts <= 3'd0;
            r_timer    <= 16'd0;
            r_best_ack <= 16'd0;
            r_best_ok  <= 1'b0;
            r_held     <= 8'd0;
        end else begin
            r_timeout  <= n_timeout;
            r_max_att  <= n_max_att;
            r_link     <= n_link;
            r_next_seq <= n_next_seq;
            r_partner  <= n_partner;
            r_awaiting <= n_awaiting;
            r_attempts <= n_attempts;
            r_timer    <= n_timer;
            r_best_ack <= n_best_ack;
            r_best_ok  <= n_best_ok;
            r_held     <= n_held;
        end
    end

    assign o_push = push;

endmodule

@@ rtl/core/swlc_back.sv @@
// back part: job queue and expansion of each job into its result items
`include "stop_and_wait_link_client_unit_assert.svh"
module swlc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swlc_pkg::t_job_push  i_push,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output swlc_pkg::t_out_item  o_item
);
    import swlc_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QCW-1:0] r_count;
    logic           r_second;

    t_job head;
    logic push_acc;
    logic pop_acc;
    logic job_done;

    assign head     = r_mem[r_rd];
    assign o_full   = (r_count == QCW'(QDEPTH));
    assign o_empty  = (r_count == '0);
    assign push_acc = i_push.valid && !o_full;
    assign pop_acc  = i_pop && !o_empty;
    assign job_done = pop_acc && (r_second || !head.two);

    // result on the ports: first result of the head job, or its trailing no-ack
    assign o_item = r_second ? mk_outcome(OUT_NO_ACK) : head.first;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_mem[r_wr] <= i_push.job;
        end
    end

    // pointers, fill count and result index within the job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            if (push_acc) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (job_done) begin
                r_rd <= r_rd + QAW'(1);
            end
            case ({push_acc, job_done})
                2'b10:   r_count <= r_count + QCW'(1);
                2'b01:   r_count <= r_count - QCW'(1);
                default: r_count <= r_count;
            endcase
            if (pop_acc) begin
                r_second <= !job_done;
            end
        end
    end

    // checks on the queue and the expander
    `SWLC_ASSERT_NOW(a_second_has_job, r_second, (r_count != '0) && head.two)
    `SWLC_ASSERT_NEXT(a_push_grows, push_acc && !job_done, r_count == $past(r_count) + QCW'(1))
    `SWLC_ASSERT_NEXT(a_done_clears_second, job_done, !r_second)
    `SWLC_ASSERT_NOW(a_count_bound, 1'b1, r_count <= QCW'(QDEPTH))

endmodule

@@ rtl/core/stop_and_wait_link_client_unit.sv @@
// top level of the stop-and-wait link client
// Usage:
//   Input channel: drive i_item and raise push; the item is taken at a clock edge
//   where push is high and full is low. Items are open, close, command,
//   received connect/status/close packets and timer ticks.
//   Result channel: while empty is low the oldest result is on o_item; it is taken
//   at a clock edge where pop is high. A result is a packet to send or the outcome
//   of a command; field last marks the final result of one input item.
//   Configuration: i_cfg_we with i_cfg_idx (0 ack timeout, 1 max attempts) and
//   i_cfg_data writes a register at the clock edge; write only while idle.
// Timing:
//   The front updates the link state in the cycle an item is taken and queues a
//   job; its first result shows on o_item at the head. One item per cycle is taken
//   while full is low. A job with two results (close packet then no-ack outcome)
//   occupies the result side for two pops. A four-entry job queue decouples the
//   two sides; when the receiver stalls, full rises once four jobs are waiting.
// Reset: synchronous, active low; link disconnected, counters zero, queue empty,
//   ack timeout 5000 ticks, max attempts 5.
module stop_and_wait_link_client_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  swlc_pkg::t_in_item   i_item,
    output logic                 empty,
    input  logic                 pop,
    output swlc_pkg::t_out_item  o_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [15:0]          i_cfg_data
);
    import swlc_pkg::*;

    t_job_push job_push;
    logic      accept;

    assign accept = push && !full;

    // front: state and classification
    swlc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_push     (job_push)
    );

    // back: job queue and result expansion
    swlc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (o_item)
    );

endmodule
